// File: sv/tslavg_pkg.sv
// ----------------------------------------------------------------------------
// tslavg_pkg
// Shared types and codes for the time-series lerp and window average block.
// ----------------------------------------------------------------------------
package tslavg_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_LERP  = 2'd1;
  localparam logic [1:0] OP_AVG   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_NCALC, S_SDIV, S_SDIVW, S_L0, S_L0C, S_LNC, S_LSRCH, S_LLO,
    S_LEVAL, S_LDIV, S_LMUL, S_LADD, S_LEND, S_AVG, S_AVGW, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ADDR_ZERO, ADDR_LAST, ADDR_ONE, ADDR_NEXT, ADDR_SEG
  } addr_sel_t;

  typedef enum logic [1:0] {
    DIV_SPAN, DIV_LAMBDA, DIV_SUM
  } div_sel_t;

  typedef enum logic [1:0] {
    VAL_RD, VAL_HI, VAL_LO, VAL_MUL
  } val_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      latch_in;
    logic      write_en;
    logic      ncalc;
    logic      div_start;
    div_sel_t  div_sel;
    logic      off_init;
    logic      off_step;
    addr_sel_t addr_sel;
    logic      m_clear;
    logic      m_inc;
    logic      cap_hi;
    logic      cap_lo;
    logic      mul;
    logic      val_load;
    val_sel_t  val_sel;
    logic      acc_add;
    logic      avg_cap;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op;
    logic       le_first;
    logic       ge_last;
    logic       search_go;
    logic       eval_hi;
    logic       eval_lo;
    logic       div_done;
    logic       last_sample;
    logic       out_free;
  } status_t;

endpackage

// File: sv/time_series_lerp_average.sv
// ----------------------------------------------------------------------------
// time_series_lerp_average
// Time-series table with point interpolation and trapezoid window average.
// ----------------------------------------------------------------------------
// A record write is done in the idle state as it is accepted. A point query
// reads the first and last records, searches segment by segment, and runs
// the weight division when the query falls inside a segment. A window average
// first divides the span into sample steps, then per sample runs one point
// query without its accept and output steps, then divides the sum and
// outputs the result. The single read port of the record memory and the
// one-bit-per-cycle divider set the run time. A new request is taken
// while a finished result still waits.
// ----------------------------------------------------------------------------
module time_series_lerp_average import tslavg_pkg::*; #(
  parameter int RECORDS     = 256,
  parameter int MAX_SAMPLES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data,       // record_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // record_index, time_point, record_value,
                                       // window_span
  input  logic [1:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // result_value
  output logic [0:0]   m_axis_tuser    // samples_clipped
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  tslavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .st       (st),
    .cmd      (cmd)
  );

  tslavg_dp #(.RECORDS(RECORDS), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser)
  );

endmodule

// File: sv/tslavg_div.sv
// ----------------------------------------------------------------------------
// tslavg_div
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module tslavg_div import tslavg_pkg::*; #(
  parameter int DDW  = 41,
  parameter int DVW  = 32,
  parameter int CNTW = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DVW-1:0]  rem_init,
  input  logic [DDW-1:0]  dividend,
  input  logic [DVW-1:0]  divisor,
  input  logic [CNTW-1:0] steps,
  output logic            busy,
  output logic            done,
  output logic [DDW-1:0]  quot,
  output logic [DVW-1:0]  rem
);

  logic [DDW-1:0]  shreg;
  logic [DVW-1:0]  dsr;
  logic [CNTW-1:0] cnt;
  logic [DVW:0]    r2;
  logic            ge;

  assign r2 = {rem, shreg[DDW-1]};
  assign ge = r2 >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      shreg <= dividend;
      dsr   <= divisor;
      quot  <= '0;
      cnt   <= steps;
    end else if (busy) begin
      rem   <= ge ? DVW'(r2 - {1'b0, dsr}) : r2[DVW-1:0];
      shreg <= {shreg[DDW-2:0], 1'b0};
      quot  <= {quot[DDW-2:0], ge};
      cnt   <= cnt - CNTW'(1);
    end
  end

endmodule

// File: sv/tslavg_ctrl.sv
// ----------------------------------------------------------------------------
// tslavg_ctrl
// Sequencer for record writes, point lerp and window average.
// ----------------------------------------------------------------------------
module tslavg_ctrl import tslavg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (st.in_op == OP_LERP) state_next = S_L0;
          else if (st.in_op == OP_AVG) state_next = S_NCALC;
        end
      end
      S_NCALC: state_next = S_SDIV;
      S_SDIV:  state_next = S_SDIVW;
      S_SDIVW: if (st.div_done) state_next = S_L0;
      S_L0:    state_next = S_L0C;
      S_L0C:   state_next = st.le_first ? S_LEND : S_LNC;
      S_LNC:   state_next = st.ge_last ? S_LEND : S_LSRCH;
      S_LSRCH: if (!st.search_go) state_next = S_LLO;
      S_LLO:   state_next = S_LEVAL;
      S_LEVAL: state_next = (st.eval_hi || st.eval_lo) ? S_LEND : S_LDIV;
      S_LDIV:  if (st.div_done) state_next = S_LMUL;
      S_LMUL:  state_next = S_LADD;
      S_LADD:  state_next = S_LEND;
      S_LEND: begin
        if (st.op == OP_LERP) state_next = S_DONE;
        else if (st.last_sample) state_next = S_AVG;
        else state_next = S_L0;
      end
      S_AVG:   state_next = S_AVGW;
      S_AVGW:  if (st.div_done) state_next = S_DONE;
      S_DONE:  if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel  = DIV_SPAN;
    cmd.addr_sel = ADDR_ZERO;
    cmd.val_sel  = VAL_RD;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.latch_in = in_valid;
        cmd.write_en = in_valid && st.in_op == OP_WRITE;
      end
      S_NCALC: cmd.ncalc = 1'b1;
      S_SDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SPAN;
      end
      S_SDIVW: cmd.off_init = st.div_done;
      S_L0:    cmd.addr_sel = ADDR_ZERO;
      S_L0C: begin
        cmd.val_load = st.le_first;
        cmd.addr_sel = ADDR_LAST;
      end
      S_LNC: begin
        cmd.val_load = st.ge_last;
        cmd.m_clear  = 1'b1;
        cmd.addr_sel = ADDR_ONE;
      end
      S_LSRCH: begin
        cmd.m_inc    = st.search_go;
        cmd.cap_hi   = !st.search_go;
        cmd.addr_sel = st.search_go ? ADDR_NEXT : ADDR_SEG;
      end
      S_LLO:   cmd.cap_lo = 1'b1;
      S_LEVAL: begin
        cmd.val_load  = st.eval_hi || st.eval_lo;
        cmd.val_sel   = st.eval_hi ? VAL_HI : VAL_LO;
        cmd.div_start = !(st.eval_hi || st.eval_lo);
        cmd.div_sel   = DIV_LAMBDA;
      end
      S_LDIV:  cmd.div_sel = DIV_LAMBDA;
      S_LMUL:  cmd.mul = 1'b1;
      S_LADD: begin
        cmd.val_load = 1'b1;
        cmd.val_sel  = VAL_MUL;
      end
      S_LEND: begin
        cmd.acc_add  = st.op == OP_AVG;
        cmd.off_step = st.op == OP_AVG && !st.last_sample;
      end
      S_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SUM;
      end
      S_AVGW:  cmd.avg_cap = st.div_done;
      S_DONE:  cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/tslavg_dp.sv
// ----------------------------------------------------------------------------
// tslavg_dp
// Record memory, sample stepping, segment weight, accumulator and output.
// ----------------------------------------------------------------------------
module tslavg_dp import tslavg_pkg::*; #(
  parameter int RECORDS     = 256,
  parameter int MAX_SAMPLES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      st,
  input  logic         cfg_valid,
  input  logic [8:0]   cfg_data,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,
  output logic [0:0]   m_tuser
);

  localparam int AW   = $clog2(RECORDS);
  localparam int CW   = $clog2(RECORDS + 1);
  localparam int NW   = $clog2(MAX_SAMPLES);
  localparam int SW   = 33 + NW;
  localparam int DDW  = SW + 1;
  localparam int CNTW = $clog2(DDW + 1);

  logic signed [31:0] times [RECORDS];
  logic signed [31:0] values [RECORDS];

  logic [8:0]         record_count;
  logic [1:0]         op;
  logic signed [31:0] t0;
  logic [30:0]        span;
  logic [NW-1:0]      nm1;
  logic               clipped;
  logic [30:0]        qs, off_q;
  logic [NW-1:0]      rs, off_r, k;
  logic [AW-1:0]      m, raddr;
  logic signed [31:0] rd_t, rd_v, t_hi, v_hi, t_lo, v_lo, val, avg;
  logic signed [63:0] prod;
  logic signed [SW-1:0] sum;

  logic [CW-1:0]      nvalid;
  logic signed [33:0] tq, num;
  logic signed [32:0] den, diff;
  logic [37:0]        p52;
  logic [22:0]        nraw;
  logic [NW:0]        rsum;
  logic [NW:0]        dsum;
  logic [DDW-1:0]     sum_mag;

  logic               div_start, div_busy, div_done;
  logic [31:0]        div_rem_init, div_divisor, div_rem;
  logic [DDW-1:0]     div_dividend, div_quot;
  logic [CNTW-1:0]    div_steps;

  always_comb begin
    if (record_count == 9'd0) nvalid = CW'(1);
    else if (32'(record_count) > RECORDS) nvalid = CW'(RECORDS);
    else nvalid = CW'(record_count);
  end

  assign tq   = 34'(t0) + $signed({3'b000, off_q});
  assign den  = 33'(t_hi) - 33'(t_lo);
  assign num  = tq - 34'(t_lo);
  assign diff = 33'(v_hi) - 33'(v_lo);
  assign p52  = {2'b00, span, 5'b0} + {3'b000, span, 4'b0} + {5'b0, span, 2'b0}
              + 38'd65535;
  assign nraw = p52[37:16] + 23'd1;
  assign rsum = {1'b0, off_r} + {1'b0, rs};
  assign dsum = {nm1, 1'b0};
  assign sum_mag = sum[SW-1] ? DDW'(-$signed({sum[SW-1], sum}) + $signed({1'b0, dsum}) - 1)
                             : DDW'(sum);

  assign st.in_op       = s_tuser;
  assign st.op          = op;
  assign st.le_first    = tq <= 34'(rd_t);
  assign st.ge_last     = tq >= 34'(rd_t);
  assign st.search_go   = ((CW+1)'(m) + (CW+1)'(2) < (CW+1)'(nvalid)) && 34'(rd_t) < tq;
  assign st.eval_hi     = den <= 33'sd0 || num >= 34'(den);
  assign st.eval_lo     = num <= 34'sd0;
  assign st.div_done    = div_done;
  assign st.last_sample = k == nm1;
  assign st.out_free    = !m_tvalid || m_tready;

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_ZERO: raddr = '0;
      ADDR_LAST: raddr = AW'(nvalid - CW'(1));
      ADDR_ONE:  raddr = AW'(1);
      ADDR_NEXT: raddr = m + AW'(2);
      ADDR_SEG:  raddr = m;
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en && 32'(s_tdata[7:0]) < RECORDS) begin
      times[AW'(s_tdata[7:0])]  <= s_tdata[39:8];
      values[AW'(s_tdata[7:0])] <= s_tdata[71:40];
    end
    rd_t <= times[raddr];
    rd_v <= values[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= 9'd1;
    end else if (cfg_valid) begin
      record_count <= cfg_data;
    end
  end

  always_comb begin
    div_start    = cmd.div_start;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = 32'(nm1);
    div_steps    = CNTW'(31);
    unique case (cmd.div_sel)
      DIV_SPAN: begin
        div_dividend = {span, {(DDW-31){1'b0}}};
      end
      DIV_LAMBDA: begin
        div_rem_init = num[31:0];
        div_divisor  = den[31:0];
        div_steps    = CNTW'(30);
      end
      DIV_SUM: begin
        div_dividend = sum_mag;
        div_divisor  = 32'(dsum);
        div_steps    = CNTW'(DDW);
      end
      default: div_steps = CNTW'(31);
    endcase
  end

  tslavg_div #(.DDW(DDW), .DVW(32), .CNTW(CNTW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op    <= s_tuser;
      t0    <= s_tdata[39:8];
      span  <= s_tdata[102:72];
      off_q <= '0;
      off_r <= '0;
      k     <= '0;
      sum   <= '0;
    end
    if (cmd.ncalc) begin
      clipped <= 23'(nraw) > 23'(MAX_SAMPLES);
      if (23'(nraw) > 23'(MAX_SAMPLES)) nm1 <= NW'(MAX_SAMPLES - 1);
      else if (nraw < 23'd2) nm1 <= NW'(1);
      else nm1 <= NW'(nraw - 23'd1);
    end
    if (cmd.off_init) begin
      qs <= div_quot[30:0];
      rs <= div_rem[NW-1:0];
    end
    if (cmd.off_step) begin
      k <= k + NW'(1);
      if (rsum >= {1'b0, nm1}) begin
        off_r <= NW'(rsum - {1'b0, nm1});
        off_q <= off_q + qs + 31'd1;
      end else begin
        off_r <= rsum[NW-1:0];
        off_q <= off_q + qs;
      end
    end
    if (cmd.m_clear) m <= '0;
    else if (cmd.m_inc) m <= m + AW'(1);
    if (cmd.cap_hi) begin
      t_hi <= rd_t;
      v_hi <= rd_v;
    end
    if (cmd.cap_lo) begin
      t_lo <= rd_t;
      v_lo <= rd_v;
    end
    if (cmd.mul) prod <= diff * $signed({1'b0, div_quot[29:0]});
    if (cmd.val_load) begin
      unique case (cmd.val_sel)
        VAL_RD:  val <= rd_v;
        VAL_HI:  val <= v_hi;
        VAL_LO:  val <= v_lo;
        VAL_MUL: val <= v_lo + prod[61:30];
        default: val <= rd_v;
      endcase
    end
    if (cmd.acc_add) begin
      if (k != '0 && k != nm1) sum <= sum + (SW'(val) <<< 1);
      else sum <= sum + SW'(val);
    end
    if (cmd.avg_cap) avg <= sum[SW-1] ? -div_quot[31:0] : div_quot[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= (op == OP_LERP) ? val : avg;
      m_tuser <= (op == OP_LERP) ? 1'b0 : clipped;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy) else $error("divider started while busy");

  a_div_run: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_busy) else $error("divider did not start");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready)) else $error("result dropped untaken");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives record writes, point queries and window averages into the block
// and checks every result against an in-bench predictor of the series or a given answer.
// ----------------------------------------------------------------------------
module testbench;
  import tslavg_pkg::*;

  localparam int RECORDS     = 256;
  localparam int MAX_SAMPLES = 64;
  localparam int WATCHDOG    = 200000;
  localparam int SETTLE      = 3000;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] tp;
    logic [31:0] val;
    logic [30:0] span;
  } request_t;

  typedef struct {
    logic [31:0] value;
    logic        clipped;
  } answer_t;

  typedef struct {
    request_t req;
    logic     known;
    answer_t  ans;
  } row_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [8:0]   cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;   // record_index, time_point, record_value, window_span
  logic [1:0]   s_axis_tuser;   // op
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;   // result_value
  logic [0:0]   m_axis_tuser;   // samples_clipped

  longint  tab_time [RECORDS];
  longint  tab_val  [RECORDS];
  int      count_reg;
  answer_t pending_answers [$];
  int      errors;
  int      idle_cycles;
  int      idle_pct;

  time_series_lerp_average #(.RECORDS(RECORDS), .MAX_SAMPLES(MAX_SAMPLES)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int live_count();
    if (count_reg == 0) return 1;
    if (count_reg > RECORDS) return RECORDS;
    return count_reg;
  endfunction

  function automatic longint lerp_series(longint t);
    int n;
    int m;
    longint den, num, lam, diff, prod;
    n = live_count();
    m = 0;
    if (t <= tab_time[0]) return tab_val[0];
    if (t >= tab_time[n-1]) return tab_val[n-1];
    while (m + 2 < n && tab_time[m+1] < t) m++;
    den = tab_time[m+1] - tab_time[m];
    num = t - tab_time[m];
    if (den <= 0 || num >= den) return tab_val[m+1];
    if (num <= 0) return tab_val[m];
    lam = (num <<< 30) / den;
    diff = tab_val[m+1] - tab_val[m];
    prod = diff * lam;
    return tab_val[m] + (prod >>> 30);
  endfunction

  function automatic answer_t window_average(longint t, longint span);
    answer_t a;
    longint n, sum, prev, cur, d;
    n = ((52 * span + 65535) >>> 16) + 1;
    a.clipped = 0;
    if (n < 2) n = 2;
    if (n > MAX_SAMPLES) begin
      n = MAX_SAMPLES;
      a.clipped = 1;
    end
    sum = 0;
    prev = lerp_series(t);
    for (longint k = 1; k < n; k++) begin
      cur = lerp_series(t + (k * span) / (n - 1));
      sum += prev + cur;
      prev = cur;
    end
    d = 2 * (n - 1);
    if (sum >= 0) sum = sum / d;
    else sum = -((-sum + d - 1) / d);
    a.value = sum[31:0];
    return a;
  endfunction

  function automatic bit predict_series(request_t r, output answer_t a);
    longint t;
    longint v;
    t = longint'($signed(r.tp));
    a.clipped = 0;
    a.value = '0;
    case (r.op)
      OP_WRITE: begin
        tab_time[r.idx] = t;
        tab_val[r.idx] = longint'($signed(r.val));
        return 0;
      end
      OP_LERP: begin
        v = lerp_series(t);
        a.value = v[31:0];
        return 1;
      end
      OP_AVG: begin
        a = window_average(t, longint'({1'b0, r.span}));
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
  endtask

  task automatic send_request(request_t r, bit known, answer_t given);
    answer_t a;
    bit has;
    idle_gap();
    s_axis_tvalid <= 1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {1'b0, r.span, r.val, r.tp, r.idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has = predict_series(r, a);
    if (has) pending_answers.push_back(known ? given : a);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(int c);
    drain();
    cfg_valid <= 1;
    cfg_data  <= c[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_reg = c;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic request_t mk(logic [1:0] op, logic [7:0] idx, longint tp,
                                  longint val, longint span);
    request_t r;
    r.op = op; r.idx = idx; r.tp = tp[31:0]; r.val = val[31:0]; r.span = span[30:0];
    return r;
  endfunction

  // store a strictly increasing series in entries 0 .. n-1
  task automatic load_series(int n, int step_max);
    longint t;
    answer_t none;
    none = '{default: 0};
    t = longint'($signed($urandom)) >>> 2;
    for (int i = 0; i < n; i++) begin
      send_request(mk(OP_WRITE, i[7:0], t, longint'($signed($urandom)), 0), 0, none);
      t += $urandom_range(step_max, 1);
    end
  endtask

  function automatic request_t random_query(int n);
    request_t r;
    longint base;
    base = tab_time[$urandom_range(n - 1)];
    r = mk(2'($urandom_range(2, 1)), 0, 0, 0, 0);
    r.idx = 8'($urandom);
    r.val = $urandom;
    case ($urandom_range(4))
      0: r.tp = $urandom;
      default: r.tp = 32'(base + longint'($signed($urandom_range(200000))) - 100000);
    endcase
    case ($urandom_range(5))
      0: r.span = 31'($urandom);
      1: r.span = 31'h7fffffff;
      2: r.span = 0;
      default: r.span = 31'($urandom_range(80000));
    endcase
    return r;
  endfunction

  initial begin
    row_t rows [$];
    answer_t none;
    int n;
    none = '{default: 0};
    errors = 0;
    idle_pct = 27;
    count_reg = 1;
    rst = 1;
    cfg_valid = 0;
    cfg_data = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // single record: every query returns that value
    rows.push_back('{mk(OP_WRITE, 0, 32'sh0001_0000, 32'sh0005_0000, 0), 0, none});
    rows.push_back('{mk(OP_LERP, 0, 32'sh8000_0000, 0, 0), 1, '{32'h0005_0000, 0}});
    rows.push_back('{mk(OP_LERP, 0, 32'sh7fff_ffff, 0, 0), 1, '{32'h0005_0000, 0}});
    rows.push_back('{mk(OP_AVG, 0, 0, 0, 0), 1, '{32'h0005_0000, 0}});
    rows.push_back('{mk(OP_AVG, 0, 0, 0, 31'h7fffffff), 1, '{32'h0005_0000, 1}});
    rows.push_back('{mk(2'd3, 8'hff, -1, -1, 31'h7fffffff), 0, none});
    rows.push_back('{mk(OP_WRITE, 1, 32'sh0003_0000, 32'sh8000_0000, 0), 0, none});
    rows.push_back('{mk(OP_WRITE, 2, 32'sh0003_0000, 32'sh7fff_ffff, 0), 0, none});
    rows.push_back('{mk(OP_WRITE, 3, 32'sh0002_0000, 32'sh0000_0000, 0), 0, none});
    rows.push_back('{mk(OP_WRITE, 8'hff, 32'sh7fff_ffff, -1, 31'h7fffffff), 0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].ans);
    rows.delete();

    // out-of-order times, repeated times and clamping
    write_count(4);
    rows.push_back('{mk(OP_LERP, 0, 32'sh0002_0000, 0, 0), 0, none});
    rows.push_back('{mk(OP_LERP, 0, 32'sh0002_8000, 0, 0), 0, none});
    rows.push_back('{mk(OP_LERP, 0, 32'sh0003_0000, 0, 0), 0, none});
    rows.push_back('{mk(OP_AVG, 0, 32'sh0001_0000, 0, 32'sh0002_0000), 0, none});
    rows.push_back('{mk(OP_AVG, 0, 32'sh0000_0000, 0, 32'sh0000_4000), 0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].ans);
    rows.delete();

    write_count(0);
    send_request(mk(OP_LERP, 0, 32'sh0004_0000, 0, 0), 1, '{32'h0005_0000, 0});
    write_count(511);
    load_series(RECORDS, 1 << 20);
    send_request(mk(OP_LERP, 0, 32'sh7fff_ffff, 0, 0), 0, none);
    send_request(mk(OP_AVG, 0, 32'sh8000_0000, 0, 31'h7fffffff), 0, none);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: n = 2;
        1: n = RECORDS;
        2: n = 256;
        default: n = $urandom_range(12, 2);
      endcase
      write_count(n);
      if (phase != 1) load_series(n, phase[0] ? 30000 : 1 << 22);
      idle_pct = (phase == 3) ? 0 : 27;
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(9) == 0)
          send_request(mk(2'($urandom_range(3)), 8'($urandom_range(n - 1)),
                          longint'($signed($urandom)), longint'($signed($urandom)), 0),
                       0, none);
        else
          send_request(random_query(n), 0, none);
        if (i == 30) drain();
      end
    end
    idle_pct = 27;
    drain();
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // receiver side: random stalls, with a quiet stretch in the middle
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h clipped=%b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        e = pending_answers.pop_front();
        if (m_axis_tdata !== e.value) begin
          errors++;
          $display("%0t: result_value expected %h actual %h", $time, e.value, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== e.clipped) begin
          errors++;
          $display("%0t: samples_clipped expected %b actual %b", $time, e.clipped,
                   m_axis_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || (pending_answers.size() == 0 && !s_axis_tvalid &&
        !cfg_valid))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("testbench: errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule

// File: filelist.f
sv/tslavg_pkg.sv
sv/tslavg_div.sv
sv/tslavg_ctrl.sv
sv/tslavg_dp.sv
sv/time_series_lerp_average.sv
tb/testbench.sv
